// ===== design/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, codes and controller/datapath handoff types for the
// positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // List geometry and field widths
  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int WEIGHT_WIDTH  = 8;
  localparam int KIND_W        = 3;
  localparam int POS_W         = 5;
  localparam int STATUS_W      = 2;
  localparam int TOTAL_W       = 5;
  localparam int LIMIT_W       = 12;
  localparam int LIMIT_RESET   = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int IDX_W         = $clog2(DEPTH);

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_RETRIEVE = 3'd2,
    KIND_REPLACE  = 3'd3,
    KIND_CLEAR    = 3'd4,
    KIND_CHECK    = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_INVALID = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted word
    logic walk_init;  // load walk pointer and entry budget
    logic rd;         // read one entry and advance the walk
    logic wr_new;     // write the word's entry at its position
    logic finish;     // commit count and load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  left_zero;
    logic  left_one;
    logic  out_free;
  } sts_t;

endpackage

// ===== design/pal_if.sv =====
// ----------------------------------------------------------------------------
// pal_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface pal_in_if #(
  parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH,
  parameter int WEIGHT_WIDTH  = pal_pkg::WEIGHT_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [pal_pkg::KIND_W-1:0]   kind;
  logic [pal_pkg::POS_W-1:0]    position;
  logic [PAYLOAD_WIDTH-1:0]     element_data;
  logic [WEIGHT_WIDTH-1:0]      element_weight;

  modport source (
    output valid, kind, position, element_data, element_weight,
    input  ready
  );
  modport sink (
    input  valid, kind, position, element_data, element_weight,
    output ready
  );
endinterface

interface pal_out_if #(
  parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH,
  parameter int WEIGHT_WIDTH  = pal_pkg::WEIGHT_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [pal_pkg::STATUS_W-1:0] status;
  logic [PAYLOAD_WIDTH-1:0]     read_data;
  logic [WEIGHT_WIDTH-1:0]      read_weight;
  logic [pal_pkg::TOTAL_W-1:0]  entry_total;
  logic                         is_empty;
  logic                         is_full;
  logic                         too_heavy;

  modport source (
    output valid, status, read_data, read_weight, entry_total, is_empty, is_full,
           too_heavy,
    input  ready
  );
  modport sink (
    input  valid, status, read_data, read_weight, entry_total, is_empty, is_full,
           too_heavy,
    output ready
  );
endinterface

// ===== design/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of payload/weight entries addressed by 1-based
// position, with insert, delete, retrieve, replace, clear and weight check.
// ----------------------------------------------------------------------------
// req carries one operation word (kind, position, element_data,
// element_weight); rsp returns exactly one result word for each.
// wr_en/wr_data load weight_limit; write it only while no word is in flight.
// One word at a time. Each word is decoded; clear, failed operations and
// unused kinds then finish, replace writes its entry first. Insert and
// delete walk the entries from the position to the end, retrieve reads one
// entry, weight check walks every stored entry; insert then writes its entry.
// An append or an empty check still enters the walk, which reads one entry
// per cycle through the single read port of the entry memory.
// rst empties the list, sets weight_limit to 16 and drops rsp.valid; entry
// contents are not cleared, as only entries below the count are read.
// The result sits in an output register. A new word is accepted while it
// waits; that word then holds in its final step until rsp is taken.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH,
  parameter int WEIGHT_WIDTH  = pal_pkg::WEIGHT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  pal_in_if.sink                      req,
  pal_out_if.source                   rsp,
  input  logic                        wr_en,
  input  logic [pal_pkg::LIMIT_W-1:0] wr_data
);

  pal_pkg::cmd_t cmd;
  pal_pkg::sts_t sts;
  logic          in_ready;

  assign req.ready = in_ready;

  // Sequencer
  pal_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  pal_datapath #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .WEIGHT_WIDTH  (WEIGHT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

endmodule

// ===== design/pal_datapath.sv =====
// ----------------------------------------------------------------------------
// pal_datapath
// Entry memory, entry count, weight limit, walk pointer, weight accumulator
// and the result register. Acts on commands from pal_controller.
// ----------------------------------------------------------------------------
module pal_datapath #(
  parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH,
  parameter int WEIGHT_WIDTH  = pal_pkg::WEIGHT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pal_pkg::cmd_t               cmd,
  output pal_pkg::sts_t               sts,
  pal_in_if.sink                      req,
  pal_out_if.source                   rsp,
  input  logic                        wr_en,
  input  logic [pal_pkg::LIMIT_W-1:0] wr_data
);

  localparam int CNT_W   = pal_pkg::CNT_W;
  localparam int IDX_W   = pal_pkg::IDX_W;
  localparam int POS_W   = pal_pkg::POS_W;
  localparam int LIMIT_W = pal_pkg::LIMIT_W;
  localparam int ENTRY_W = PAYLOAD_WIDTH + WEIGHT_WIDTH;
  localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int SUM_W   = (WEIGHT_WIDTH + CNT_W > LIMIT_W) ? WEIGHT_WIDTH + CNT_W : LIMIT_W;

  // Captured word
  pal_pkg::kind_t           kind_q;
  logic [POS_W-1:0]         pos_q;
  logic [PAYLOAD_WIDTH-1:0] data_q;
  logic [WEIGHT_WIDTH-1:0]  wt_q;

  // Architectural state
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [LIMIT_W-1:0]       limit;
  logic [ENTRY_W-1:0]       mem [pal_pkg::DEPTH];

  // Walk and read-data handling
  logic [IDX_W-1:0]         ra;
  logic [CNT_W-1:0]         left;
  logic [ENTRY_W-1:0]       rd_q;
  logic                     wb_q;
  logic [IDX_W-1:0]         wb_addr_q;
  logic                     cap_q;
  logic                     acc_q;
  logic [SUM_W-1:0]         sum;
  logic [PAYLOAD_WIDTH-1:0] res_data;
  logic [WEIGHT_WIDTH-1:0]  res_wt;

  // Decode helpers
  logic [POS_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         p0;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     pos_zero;
  logic                     past_count;
  logic                     past_append;
  logic                     list_full;
  logic                     list_empty;
  pal_pkg::status_t         status;
  logic                     heavy;

  // Memory port
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [ENTRY_W-1:0]       mem_wdata;

  // Position arithmetic
  always_comb begin
    pos_m1      = pos_q - POS_W'(1);
    p0          = pos_m1[IDX_W-1:0];
    pos_ext     = CMP_W'(pos_q);
    cnt_ext     = CMP_W'(count);
    pos_zero    = (pos_q == '0);
    past_count  = (pos_ext > cnt_ext);
    past_append = (pos_ext > (cnt_ext + CMP_W'(1)));
    list_full   = (count == CNT_W'(pal_pkg::DEPTH));
    list_empty  = (count == '0);
  end

  // Classify the captured word
  always_comb begin
    status = pal_pkg::STATUS_OK;
    unique case (kind_q) inside
      pal_pkg::KIND_INSERT: begin
        if (list_full) begin
          status = pal_pkg::STATUS_FULL;
        end else if (pos_zero || past_append) begin
          status = pal_pkg::STATUS_INVALID;
        end
      end
      pal_pkg::KIND_DELETE: begin
        if (list_empty) begin
          status = pal_pkg::STATUS_EMPTY;
        end else if (pos_zero || past_count) begin
          status = pal_pkg::STATUS_INVALID;
        end
      end
      pal_pkg::KIND_RETRIEVE, pal_pkg::KIND_REPLACE: begin
        if (pos_zero || past_count) begin
          status = pal_pkg::STATUS_INVALID;
        end
      end
      default: begin
        status = pal_pkg::STATUS_OK;
      end
    endcase
  end

  // Count after the operation
  always_comb begin
    count_next = count;
    if (status == pal_pkg::STATUS_OK) begin
      case (kind_q)
        pal_pkg::KIND_INSERT: count_next = count + CNT_W'(1);
        pal_pkg::KIND_DELETE: count_next = count - CNT_W'(1);
        pal_pkg::KIND_CLEAR:  count_next = '0;
        default:              count_next = count;
      endcase
    end
  end

  // Weight check against the limit
  assign heavy = (kind_q == pal_pkg::KIND_CHECK) &&
                 ((sum + SUM_W'(wt_q)) > SUM_W'(limit));

  // Status back to the controller
  always_comb begin
    sts.kind      = kind_q;
    sts.err       = (status != pal_pkg::STATUS_OK);
    sts.left_zero = (left == '0);
    sts.left_one  = (left == CNT_W'(1));
    sts.out_free  = !rsp.valid || rsp.ready;
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= pal_pkg::kind_t'(req.kind);
      pos_q  <= req.position;
      data_q <= req.element_data;
      wt_q   <= req.element_weight;
    end
  end

  // Hold the weight limit
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(pal_pkg::LIMIT_RESET);
    end else if (wr_en) begin
      limit <= wr_data;
    end
  end

  // Advance the walk pointer and entry budget
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      case (kind_q)
        pal_pkg::KIND_INSERT: begin
          ra   <= IDX_W'(count - CNT_W'(1));
          left <= count - CNT_W'(p0);
        end
        pal_pkg::KIND_DELETE: begin
          ra   <= p0;
          left <= count - CNT_W'(p0);
        end
        pal_pkg::KIND_RETRIEVE: begin
          ra   <= p0;
          left <= CNT_W'(1);
        end
        pal_pkg::KIND_CHECK: begin
          ra   <= '0;
          left <= count;
        end
        default: begin
          ra   <= p0;
          left <= '0;
        end
      endcase
    end else if (cmd.rd) begin
      left <= left - CNT_W'(1);
      if (kind_q == pal_pkg::KIND_INSERT) begin
        ra <= ra - IDX_W'(1);
      end else begin
        ra <= ra + IDX_W'(1);
      end
    end
  end

  // Tag each read with what to do with its data next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_q  <= 1'b0;
      cap_q <= 1'b0;
      acc_q <= 1'b0;
    end else begin
      wb_q  <= cmd.rd && ((kind_q == pal_pkg::KIND_INSERT) ||
                          ((kind_q == pal_pkg::KIND_DELETE) && (ra != p0)));
      cap_q <= cmd.rd && ((kind_q == pal_pkg::KIND_RETRIEVE) ||
                          ((kind_q == pal_pkg::KIND_DELETE) && (ra == p0)));
      acc_q <= cmd.rd && (kind_q == pal_pkg::KIND_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (kind_q == pal_pkg::KIND_INSERT) begin
      wb_addr_q <= ra + IDX_W'(1);
    end else begin
      wb_addr_q <= ra - IDX_W'(1);
    end
  end

  // Select the memory write: a moved entry or the new entry
  always_comb begin
    mem_we    = wb_q || cmd.wr_new;
    mem_waddr = wb_q ? wb_addr_q : p0;
    mem_wdata = wb_q ? rd_q : {wt_q, data_q};
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_q <= mem[ra];
    end
  end

  // Collect read data and weight sum
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum      <= '0;
      res_data <= '0;
      res_wt   <= '0;
    end else begin
      if (cap_q) begin
        res_data <= rd_q[PAYLOAD_WIDTH-1:0];
        res_wt   <= rd_q[ENTRY_W-1 -: WEIGHT_WIDTH];
      end
      if (acc_q) begin
        sum <= sum + SUM_W'(rd_q[ENTRY_W-1 -: WEIGHT_WIDTH]);
      end
    end
  end

  // Commit the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  // Result register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status      <= status;
      rsp.read_data   <= res_data;
      rsp.read_weight <= res_wt;
      rsp.entry_total <= pal_pkg::TOTAL_W'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CNT_W'(pal_pkg::DEPTH));
      rsp.too_heavy   <= heavy;
    end
  end

endmodule

// ===== design/pal_controller.sv =====
// ----------------------------------------------------------------------------
// pal_controller
// Sequencer for one word at a time: decode, walk the stored entries, write
// the new entry and hand the result to the output register.
// ----------------------------------------------------------------------------
module pal_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pal_pkg::sts_t sts,
  output pal_pkg::cmd_t cmd
);

  pal_pkg::state_t state;
  pal_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pal_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pal_pkg::ST_DECODE;
        end
      end
      pal_pkg::ST_DECODE: begin
        if (sts.err) begin
          state_next = pal_pkg::ST_FINISH;
        end else begin
          case (sts.kind) inside
            pal_pkg::KIND_INSERT, pal_pkg::KIND_DELETE,
            pal_pkg::KIND_RETRIEVE, pal_pkg::KIND_CHECK: state_next = pal_pkg::ST_WALK;
            pal_pkg::KIND_REPLACE:                       state_next = pal_pkg::ST_WRITE;
            default:                                     state_next = pal_pkg::ST_FINISH;
          endcase
        end
      end
      pal_pkg::ST_WALK: begin
        if (sts.left_zero || sts.left_one) begin
          state_next = pal_pkg::ST_DRAIN;
        end
      end
      pal_pkg::ST_DRAIN: begin
        if (sts.kind == pal_pkg::KIND_INSERT) begin
          state_next = pal_pkg::ST_WRITE;
        end else begin
          state_next = pal_pkg::ST_FINISH;
        end
      end
      pal_pkg::ST_WRITE: begin
        state_next = pal_pkg::ST_FINISH;
      end
      pal_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          state_next = pal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pal_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      pal_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pal_pkg::ST_DECODE: begin
        // clear the read fields and the sum for every word, failed ones too
        cmd.walk_init = 1'b1;
      end
      pal_pkg::ST_WALK: begin
        cmd.rd = !sts.left_zero;
      end
      pal_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      pal_pkg::ST_WRITE: begin
        cmd.wr_new = 1'b1;
      end
      pal_pkg::ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks on the result channel of positional_array_list.
// ----------------------------------------------------------------------------
module pal_checker #(
  parameter int PAYLOAD_WIDTH = pal_pkg::PAYLOAD_WIDTH,
  parameter int WEIGHT_WIDTH  = pal_pkg::WEIGHT_WIDTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [pal_pkg::STATUS_W-1:0] rsp_status,
  input logic [PAYLOAD_WIDTH-1:0]     rsp_read_data,
  input logic [WEIGHT_WIDTH-1:0]      rsp_read_weight,
  input logic [pal_pkg::TOTAL_W-1:0]  rsp_entry_total,
  input logic                         rsp_is_empty,
  input logic                         rsp_is_full,
  input logic                         rsp_too_heavy
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // Flags agree with the reported count
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_entry_total == '0)) &&
                  (rsp_is_full == (rsp_entry_total == pal_pkg::TOTAL_W'(pal_pkg::DEPTH))))
    else $error("empty/full flags disagree with entry_total");

  // Count never exceeds the list depth
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_entry_total <= pal_pkg::TOTAL_W'(pal_pkg::DEPTH)))
    else $error("entry_total beyond depth");

  // A failed operation returns no data and no weight verdict
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != pal_pkg::STATUS_OK) |->
      (rsp_read_data == '0) && (rsp_read_weight == '0) && !rsp_too_heavy)
    else $error("failed operation carries read data or too_heavy");

endmodule

bind positional_array_list pal_checker #(
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
  .WEIGHT_WIDTH  (WEIGHT_WIDTH)
) u_pal_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_data   (rsp.read_data),
  .rsp_read_weight (rsp.read_weight),
  .rsp_entry_total (rsp.entry_total),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_is_full     (rsp.is_full),
  .rsp_too_heavy   (rsp.too_heavy)
);
